/* hw/rtl/affine_vertex_transform_assert.svh */
// Assertion macros shared by the RTL.
`ifndef AFFINE_VERTEX_TRANSFORM_ASSERT_SVH
`define AFFINE_VERTEX_TRANSFORM_ASSERT_SVH

// cond must hold in the same cycle as trig
`define AVT_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// trig must be followed by cond (delayed check)
`define AVT_ASSERT_LAT3(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##3 (cond)) \
      else $error("assertion failed");

`endif

/* hw/rtl/avt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package avt_pkg;

   localparam int MAT_W      = 64;
   localparam int ELEM_W     = 16;
   localparam int POS_W      = 32;
   localparam int NORM_W     = 16;
   localparam int ONORM_W    = 24;
   localparam int TEX_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int RND_BITS   = 12;
   localparam int PPROD_W    = ELEM_W + POS_W;
   localparam int NPROD_W    = ELEM_W + NORM_W;
   localparam int PSUM_W     = PPROD_W + 2;
   localparam int NSUM_W     = NPROD_W + 3;
   localparam int PRND_W     = PSUM_W - RND_BITS;
   localparam int NRND_W     = NSUM_W - RND_BITS;

   localparam logic [MAT_W-1:0] MAT_RESET_X = 64'h0000_0000_0000_1000;
   localparam logic [MAT_W-1:0] MAT_RESET_Y = 64'h0000_0000_1000_0000;
   localparam logic [MAT_W-1:0] MAT_RESET_Z = 64'h0000_1000_0000_0000;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_X = 2'd0,
      REG_ROW_Y = 2'd1,
      REG_ROW_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [PPROD_W-1:0] p0;
      logic signed [PPROD_W-1:0] p1;
      logic signed [PPROD_W-1:0] p2;
      logic signed [ELEM_W-1:0]  trans;
      logic signed [NPROD_W-1:0] n0;
      logic signed [NPROD_W-1:0] n1;
      logic signed [NPROD_W-1:0] n2;
   } row_prod_type;

   typedef struct packed {
      logic signed [POS_W-1:0]   pos;
      logic signed [ONORM_W-1:0] norm;
      logic                      ovf;
   } row_res_type;

endpackage

`default_nettype wire

/* hw/rtl/affine_vertex_transform.sv */
// Affine vertex transform: position by the top three rows of a 4x4 Q4.12 matrix
// (rotation plus translation), normal by its upper 3x3, texture coordinate copied.
// Input: a vertex beat is taken at a clock edge with start high and busy low.
// busy is never raised, so a vertex may be started every cycle.
// Output: rsp_valid is high for exactly one cycle per vertex with all result
// ports valid in that cycle; the receiver cannot stall, results are not held.
// Pipeline: an accepted vertex passes the input register, multiplier register and
// sum/round/saturate register before rsp_valid.
// Throughput: one vertex per cycle, set by the fully pipelined multiply stage.
// Out-of-range positions saturate and raise rsp_overflow.
// Configuration: csr_wr_en writes matrix row csr_index (0..2) with csr_wr_data;
// other indexes are ignored. Write only while no vertex is in flight.
// Reset (synchronous, active high) loads the identity matrix and drops any
// vertex in flight.
`timescale 1ns / 1ps
`default_nettype none

module affine_vertex_transform (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [avt_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic signed [avt_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic signed [avt_pkg::POS_W-1:0]    req_pos_z,
   input  wire logic signed [avt_pkg::NORM_W-1:0]   req_norm_x,
   input  wire logic signed [avt_pkg::NORM_W-1:0]   req_norm_y,
   input  wire logic signed [avt_pkg::NORM_W-1:0]   req_norm_z,
   input  wire logic        [avt_pkg::TEX_W-1:0]    req_tex_u,
   input  wire logic        [avt_pkg::TEX_W-1:0]    req_tex_v,
   output logic                                     rsp_valid,
   output logic signed      [avt_pkg::POS_W-1:0]    rsp_out_pos_x,
   output logic signed      [avt_pkg::POS_W-1:0]    rsp_out_pos_y,
   output logic signed      [avt_pkg::POS_W-1:0]    rsp_out_pos_z,
   output logic signed      [avt_pkg::ONORM_W-1:0]  rsp_out_norm_x,
   output logic signed      [avt_pkg::ONORM_W-1:0]  rsp_out_norm_y,
   output logic signed      [avt_pkg::ONORM_W-1:0]  rsp_out_norm_z,
   output logic             [avt_pkg::TEX_W-1:0]    rsp_out_tex_u,
   output logic             [avt_pkg::TEX_W-1:0]    rsp_out_tex_v,
   output logic                                     rsp_overflow,
   input  wire logic                                csr_wr_en,
   input  wire logic        [avt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [avt_pkg::MAT_W-1:0]    csr_wr_data
);
   import avt_pkg::*;

   `include "affine_vertex_transform_assert.svh"

   logic [MAT_W-1:0] row_x, row_y, row_z;
   logic             accept;

   logic                     v0_ff, v1_ff, v2_ff;
   logic                     v0_in, v1_in, v2_in;
   logic signed [POS_W-1:0]  px_ff, py_ff, pz_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic [TEX_W-1:0]         u0_ff, v0t_ff, u1_ff, v1t_ff, u2_ff, v2t_ff;

   row_prod_type prod_x, prod_y, prod_z;
   row_res_type  res_x, res_y, res_z;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   avt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .row_x       (row_x),
      .row_y       (row_y),
      .row_z       (row_z)
   );

   assign v0_in = accept;
   assign v1_in = v0_ff;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         pz_ff  <= req_pos_z;
         nx_ff  <= req_norm_x;
         ny_ff  <= req_norm_y;
         nz_ff  <= req_norm_z;
         u0_ff  <= req_tex_u;
         v0t_ff <= req_tex_v;
      end
      u1_ff  <= u0_ff;
      v1t_ff <= v0t_ff;
      u2_ff  <= u1_ff;
      v2t_ff <= v1t_ff;
   end

   avt_mul_stage u_mul_x (
      .clock (clock), .row (row_x),
      .pos_x (px_ff), .pos_y (py_ff), .pos_z (pz_ff),
      .norm_x (nx_ff), .norm_y (ny_ff), .norm_z (nz_ff),
      .prod  (prod_x)
   );

   avt_mul_stage u_mul_y (
      .clock (clock), .row (row_y),
      .pos_x (px_ff), .pos_y (py_ff), .pos_z (pz_ff),
      .norm_x (nx_ff), .norm_y (ny_ff), .norm_z (nz_ff),
      .prod  (prod_y)
   );

   avt_mul_stage u_mul_z (
      .clock (clock), .row (row_z),
      .pos_x (px_ff), .pos_y (py_ff), .pos_z (pz_ff),
      .norm_x (nx_ff), .norm_y (ny_ff), .norm_z (nz_ff),
      .prod  (prod_z)
   );

   avt_sum_stage u_sum_x (.clock (clock), .prod (prod_x), .res (res_x));
   avt_sum_stage u_sum_y (.clock (clock), .prod (prod_y), .res (res_y));
   avt_sum_stage u_sum_z (.clock (clock), .prod (prod_z), .res (res_z));

   assign rsp_valid      = v2_ff;
   assign rsp_out_pos_x  = res_x.pos;
   assign rsp_out_pos_y  = res_y.pos;
   assign rsp_out_pos_z  = res_z.pos;
   assign rsp_out_norm_x = res_x.norm;
   assign rsp_out_norm_y = res_y.norm;
   assign rsp_out_norm_z = res_z.norm;
   assign rsp_out_tex_u  = u2_ff;
   assign rsp_out_tex_v  = v2t_ff;
   assign rsp_overflow   = res_x.ovf | res_y.ovf | res_z.ovf;

   `AVT_ASSERT_LAT3(a_beat_latency, clock, reset, accept, rsp_valid)
   `AVT_ASSERT_SAME(a_no_orphan_rsp, clock, reset, rsp_valid, $past(accept, 3))
   `AVT_ASSERT_SAME(a_tex_passthru, clock, reset, rsp_valid,
      (rsp_out_tex_u == $past(req_tex_u, 3)) && (rsp_out_tex_v == $past(req_tex_v, 3)))
   `AVT_ASSERT_SAME(a_ovf_saturated, clock, reset, rsp_valid && rsp_overflow,
      (rsp_out_pos_x == POS_MAX) || (rsp_out_pos_x == POS_MIN) ||
      (rsp_out_pos_y == POS_MAX) || (rsp_out_pos_y == POS_MIN) ||
      (rsp_out_pos_z == POS_MAX) || (rsp_out_pos_z == POS_MIN))

endmodule

`default_nettype wire

/* hw/rtl/avt_csr.sv */
`timescale 1ns / 1ps
`default_nettype none

module avt_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [avt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [avt_pkg::MAT_W-1:0]       csr_wr_data,
   output logic      [avt_pkg::MAT_W-1:0]       row_x,
   output logic      [avt_pkg::MAT_W-1:0]       row_y,
   output logic      [avt_pkg::MAT_W-1:0]       row_z
);
   import avt_pkg::*;

   logic [MAT_W-1:0] row_x_ff, row_y_ff, row_z_ff;
   logic [MAT_W-1:0] row_x_in, row_y_in, row_z_in;

   always_comb begin
      row_x_in = row_x_ff;
      row_y_in = row_y_ff;
      row_z_in = row_z_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROW_X: row_x_in = csr_wr_data;
            REG_ROW_Y: row_y_in = csr_wr_data;
            REG_ROW_Z: row_z_in = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= MAT_RESET_X;
         row_y_ff <= MAT_RESET_Y;
         row_z_ff <= MAT_RESET_Z;
      end else begin
         row_x_ff <= row_x_in;
         row_y_ff <= row_y_in;
         row_z_ff <= row_z_in;
      end
   end

   assign row_x = row_x_ff;
   assign row_y = row_y_ff;
   assign row_z = row_z_ff;

endmodule

`default_nettype wire

/* hw/rtl/avt_mul_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module avt_mul_stage (
   input  wire logic                                clock,
   input  wire logic        [avt_pkg::MAT_W-1:0]    row,
   input  wire logic signed [avt_pkg::POS_W-1:0]    pos_x,
   input  wire logic signed [avt_pkg::POS_W-1:0]    pos_y,
   input  wire logic signed [avt_pkg::POS_W-1:0]    pos_z,
   input  wire logic signed [avt_pkg::NORM_W-1:0]   norm_x,
   input  wire logic signed [avt_pkg::NORM_W-1:0]   norm_y,
   input  wire logic signed [avt_pkg::NORM_W-1:0]   norm_z,
   output avt_pkg::row_prod_type                    prod
);
   import avt_pkg::*;

   logic signed [ELEM_W-1:0] m0, m1, m2;
   row_prod_type             prod_ff, prod_in;

   assign m0 = $signed(row[ELEM_W-1:0]);
   assign m1 = $signed(row[2*ELEM_W-1:ELEM_W]);
   assign m2 = $signed(row[3*ELEM_W-1:2*ELEM_W]);

   always_comb begin
      prod_in.p0    = PPROD_W'(m0) * PPROD_W'(pos_x);
      prod_in.p1    = PPROD_W'(m1) * PPROD_W'(pos_y);
      prod_in.p2    = PPROD_W'(m2) * PPROD_W'(pos_z);
      prod_in.trans = $signed(row[4*ELEM_W-1:3*ELEM_W]);
      prod_in.n0    = NPROD_W'(m0) * NPROD_W'(norm_x);
      prod_in.n1    = NPROD_W'(m1) * NPROD_W'(norm_y);
      prod_in.n2    = NPROD_W'(m2) * NPROD_W'(norm_z);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* hw/rtl/avt_sum_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module avt_sum_stage (
   input  wire logic                  clock,
   input  wire avt_pkg::row_prod_type prod,
   output avt_pkg::row_res_type       res
);
   import avt_pkg::*;

   logic signed [PSUM_W-1:0] psum;
   logic signed [NSUM_W-1:0] nsum;
   logic signed [PRND_W-1:0] prnd;
   logic signed [NRND_W-1:0] nrnd;
   logic                     p_hi, p_lo;
   row_res_type              res_ff, res_in;

   // round half up: add half an LSB, then arithmetic drop
   assign psum = PSUM_W'(prod.p0) + PSUM_W'(prod.p1) + PSUM_W'(prod.p2)
               + PSUM_W'($signed({prod.trans, {(POS_W-ELEM_W){1'b0}}}))
               + PSUM_W'(1 << (RND_BITS-1));
   assign nsum = NSUM_W'(prod.n0) + NSUM_W'(prod.n1) + NSUM_W'(prod.n2)
               + NSUM_W'(1 << (RND_BITS-1));
   assign prnd = psum[PSUM_W-1:RND_BITS];
   assign nrnd = nsum[NSUM_W-1:RND_BITS];

   assign p_hi = (prnd > PRND_W'(POS_MAX));
   assign p_lo = (prnd < PRND_W'(POS_MIN));

   always_comb begin
      priority if (p_hi) begin
         res_in.pos = POS_MAX;
      end else if (p_lo) begin
         res_in.pos = POS_MIN;
      end else begin
         res_in.pos = prnd[POS_W-1:0];
      end
      // three Q2.14 x Q4.12 products stay well inside 24 bits after rounding
      res_in.norm = ONORM_W'(nrnd);
      res_in.ovf  = p_hi | p_lo;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire
